FILE: design/imi_pkg.sv
package imi_pkg;

  // Table geometry
  localparam int ADV_DEPTH = 16;
  localparam int DWL_DEPTH = 16;
  localparam int MAX_DEPTH = (ADV_DEPTH > DWL_DEPTH) ? ADV_DEPTH : DWL_DEPTH;
  localparam int ADV_AW    = $clog2(ADV_DEPTH);
  localparam int DWL_AW    = $clog2(DWL_DEPTH);
  localparam int IDX_W     = $clog2(MAX_DEPTH);
  localparam int CNT_W     = $clog2(MAX_DEPTH + 1);

  // Field and register widths
  localparam int PTS_W  = 5;
  localparam int VAL_W  = 16;
  localparam int APB_AW = 5;

  // Divider: the quotient never exceeds 16 bits, so 16 steps suffice
  localparam int DIV_STEPS = 16;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  // Advance returned when the advance table is empty
  localparam logic [VAL_W-1:0] ADV_EMPTY_CD = 16'd1200;

  // Register reset values
  localparam logic [VAL_W-1:0] DWL_DEF_RST   = 16'd3000;
  localparam logic [VAL_W-1:0] DWL_FLOOR_RST = 16'd1000;
  localparam logic [VAL_W-1:0] DWL_CEIL_RST  = 16'd8000;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_WR_ADV = 2'd1,
    MODE_WR_DWL = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_ADV_PTS   = 3'd0,
    REG_DWL_PTS   = 3'd1,
    REG_DWL_DEF   = 3'd2,
    REG_DWL_FLOOR = 3'd3,
    REG_DWL_CEIL  = 3'd4
  } reg_idx_t;

  typedef enum logic {
    TBL_ADV = 1'b0,
    TBL_DWL = 1'b1
  } tbl_t;

  typedef enum logic [1:0] {
    RES_CUR    = 2'd0,
    RES_INTERP = 2'd1,
    RES_EMPTY  = 2'd2
  } res_src_t;

  typedef struct packed {
    logic [PTS_W-1:0] adv_pts;
    logic [PTS_W-1:0] dwl_pts;
    logic [VAL_W-1:0] dwl_default;
    logic [VAL_W-1:0] dwl_floor;
    logic [VAL_W-1:0] dwl_ceiling;
  } cfg_t;

  typedef struct packed {
    logic             wr_adv;
    logic             wr_dwl;
    logic             load_rpm;
    tbl_t             tsel;
    logic             rd;
    logic [IDX_W-1:0] addr;
    logic             save_prev;
    logic             mul;
    logic             div_step;
    logic             res_we;
    res_src_t         res_src;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic le;
    logic seg_up;
  } stat_t;

endpackage

FILE: design/ignition_map_interpolator_top.sv
// Ignition map interpolator. Holds an advance table and a dwell table of
// rpm breakpoints (16 each), loaded by write words (mode 1 advance, mode 2
// dwell, no result). A lookup word (mode 0) returns both the interpolated
// advance and the clamped dwell. Each table is scanned one breakpoint at a
// time through a single registered read port (read in S_RD, compared in
// S_CMP), and a segment that needs interpolation goes through a 16x16
// multiply and a 16-step restoring divider. A lookup holds the block from
// its accepting edge through the search of both tables and any divide,
// and a finished result waits in S_DONE until the output word is free.
// The next item is taken while the last result still waits at the output.
// Configuration registers sit on the APB port at 4-byte spacing: advance
// point count, dwell point count, dwell default, dwell floor, dwell ceiling.
module ignition_map_interpolator_top (
  input  logic                        clk,
  input  logic                        rst,
  // Item channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  mode,
  input  logic [3:0]                  entry_index,
  input  logic [15:0]                 rpm,
  input  logic [15:0]                 entry_value,
  // Result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [15:0]          advance_cd,
  output logic [15:0]                 dwell_time,
  // Register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [imi_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import imi_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic  reg_wr;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.adv_pts     <= '0;
      cfg.dwl_pts     <= '0;
      cfg.dwl_default <= DWL_DEF_RST;
      cfg.dwl_floor   <= DWL_FLOOR_RST;
      cfg.dwl_ceiling <= DWL_CEIL_RST;
    end else if (reg_wr) begin
      unique case (paddr[APB_AW-1:2])
        REG_ADV_PTS:   cfg.adv_pts     <= pwdata[PTS_W-1:0];
        REG_DWL_PTS:   cfg.dwl_pts     <= pwdata[PTS_W-1:0];
        REG_DWL_DEF:   cfg.dwl_default <= pwdata[VAL_W-1:0];
        REG_DWL_FLOOR: cfg.dwl_floor   <= pwdata[VAL_W-1:0];
        REG_DWL_CEIL:  cfg.dwl_ceiling <= pwdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[APB_AW-1:2])
      REG_ADV_PTS:   prdata = 32'(cfg.adv_pts);
      REG_DWL_PTS:   prdata = 32'(cfg.dwl_pts);
      REG_DWL_DEF:   prdata = 32'(cfg.dwl_default);
      REG_DWL_FLOOR: prdata = 32'(cfg.dwl_floor);
      REG_DWL_CEIL:  prdata = 32'(cfg.dwl_ceiling);
      default:       prdata = '0;
    endcase
  end

  imi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .cfg       (cfg),
    .stat      (stat),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  imi_dp u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .stat        (stat),
    .cfg         (cfg),
    .entry_index (entry_index),
    .rpm         (rpm),
    .entry_value (entry_value),
    .advance_cd  (advance_cd),
    .dwell_time  (dwell_time)
  );

endmodule

FILE: design/imi_dp.sv
module imi_dp (
  input  logic                     clk,
  input  imi_pkg::cmd_t            cmd,
  output imi_pkg::stat_t           stat,
  input  imi_pkg::cfg_t            cfg,
  input  logic [3:0]               entry_index,
  input  logic [15:0]              rpm,
  input  logic [15:0]              entry_value,
  output logic signed [15:0]       advance_cd,
  output logic [15:0]              dwell_time
);
  import imi_pkg::*;

  // Breakpoint stores
  logic [VAL_W-1:0] adv_sp  [ADV_DEPTH];
  logic [VAL_W-1:0] adv_val [ADV_DEPTH];
  logic [VAL_W-1:0] dwl_sp  [DWL_DEPTH];
  logic [VAL_W-1:0] dwl_val [DWL_DEPTH];

  logic [VAL_W-1:0] sp_q, val_q;
  logic [VAL_W-1:0] rpm_r;
  logic [VAL_W-1:0] x0;
  logic [16:0]      y0;
  logic [VAL_W-1:0] dvs;
  logic [VAL_W-1:0] rem;
  logic [VAL_W-1:0] qsh;
  logic             neg;
  logic [VAL_W-1:0] adv_r, dwl_r;

  logic [16:0] cur_y;
  logic [17:0] dy, mag;
  logic [15:0] dx;
  logic [31:0] prod;
  logic [16:0] shl;
  logic [17:0] diff;
  logic [17:0] q18, interp, res_val;
  logic [15:0] dwl_c;

  // Write breakpoints; slots beyond the depth are dropped
  always_ff @(posedge clk) begin
    if (cmd.wr_adv && int'(entry_index) < ADV_DEPTH) begin
      adv_sp[ADV_AW'(entry_index)]  <= rpm;
      adv_val[ADV_AW'(entry_index)] <= entry_value;
    end
    if (cmd.wr_dwl && int'(entry_index) < DWL_DEPTH) begin
      dwl_sp[DWL_AW'(entry_index)]  <= rpm;
      dwl_val[DWL_AW'(entry_index)] <= entry_value;
    end
  end

  // Registered read of the selected table
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      if (cmd.tsel == TBL_ADV) begin
        sp_q  <= adv_sp[cmd.addr[ADV_AW-1:0]];
        val_q <= adv_val[cmd.addr[ADV_AW-1:0]];
      end else begin
        sp_q  <= dwl_sp[cmd.addr[DWL_AW-1:0]];
        val_q <= dwl_val[cmd.addr[DWL_AW-1:0]];
      end
    end
  end

  // Current point value: advance is signed, dwell is unsigned
  assign cur_y = (cmd.tsel == TBL_ADV) ? {val_q[15], val_q} : {1'b0, val_q};

  assign stat.le     = (rpm_r <= sp_q);
  assign stat.seg_up = (sp_q > x0);

  // Segment setup and magnitude product
  assign dy   = {cur_y[16], cur_y} - {y0[16], y0};
  assign mag  = dy[17] ? (18'd0 - dy) : dy;
  assign dx   = rpm_r - x0;
  assign prod = dx * mag[15:0];

  // One restoring division step
  assign shl  = {rem, qsh[15]};
  assign diff = {1'b0, shl} - {2'b00, dvs};

  // Interpolated value, quotient truncated toward zero
  assign q18    = {2'b00, qsh};
  assign interp = {y0[16], y0} + (neg ? (18'd0 - q18) : q18);

  always_comb begin
    unique case (cmd.res_src)
      RES_CUR:    res_val = {cur_y[16], cur_y};
      RES_INTERP: res_val = interp;
      default:    res_val = '0;
    endcase
  end

  // Dwell: raise to floor, then cut to ceiling
  always_comb begin
    dwl_c = res_val[15:0];
    if (dwl_c < cfg.dwl_floor) dwl_c = cfg.dwl_floor;
    if (dwl_c > cfg.dwl_ceiling) dwl_c = cfg.dwl_ceiling;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load_rpm) rpm_r <= rpm;
    if (cmd.save_prev) begin
      x0 <= sp_q;
      y0 <= cur_y;
    end
    if (cmd.mul) begin
      neg <= dy[17];
      dvs <= sp_q - x0;
      rem <= prod[31:16];
      qsh <= prod[15:0];
    end else if (cmd.div_step) begin
      rem <= diff[17] ? shl[15:0] : diff[15:0];
      qsh <= {qsh[14:0], ~diff[17]};
    end
    if (cmd.res_we) begin
      if (cmd.tsel == TBL_ADV) begin
        adv_r <= (cmd.res_src == RES_EMPTY) ? ADV_EMPTY_CD : res_val[15:0];
      end else begin
        dwl_r <= (cmd.res_src == RES_EMPTY) ? cfg.dwl_default : dwl_c;
      end
    end
    if (cmd.out_load) begin
      advance_cd <= adv_r;
      dwell_time <= dwl_r;
    end
  end

endmodule

FILE: design/imi_ctrl.sv
module imi_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                mode,
  input  imi_pkg::cfg_t             cfg,
  input  imi_pkg::stat_t            stat,
  output imi_pkg::cmd_t             cmd,
  output logic                      out_valid,
  input  logic                      out_ready
);
  import imi_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_RD,
    S_CMP,
    S_MUL,
    S_DIV,
    S_FIN,
    S_DONE
  } state_t;

  state_t           state, state_next;
  tbl_t             tsel, tsel_next;
  logic [IDX_W-1:0] addr, addr_next;
  logic [DIV_CW-1:0] cnt, cnt_next;
  logic             out_valid_next;
  logic [CNT_W-1:0] npts;
  logic             in_fire, last_pt, out_free;

  function automatic logic [CNT_W-1:0] sat_pts(logic [PTS_W-1:0] p, int depth);
    if (int'(p) > depth) return CNT_W'(depth);
    return CNT_W'(p);
  endfunction

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign npts     = (tsel == TBL_ADV) ? sat_pts(cfg.adv_pts, ADV_DEPTH)
                                      : sat_pts(cfg.dwl_pts, DWL_DEPTH);
  assign last_pt  = (int'(addr) + 1 == int'(npts));
  assign out_free = !out_valid || out_ready;

  // Sequence the search, divide and result handoff
  always_comb begin
    state_next     = state;
    tsel_next      = tsel;
    addr_next      = addr;
    cnt_next       = cnt;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.tsel       = tsel;
    cmd.addr       = addr;
    cmd.res_src    = RES_CUR;

    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.wr_adv = (mode == MODE_WR_ADV);
          cmd.wr_dwl = (mode == MODE_WR_DWL);
          if (mode == MODE_LOOKUP) begin
            cmd.load_rpm = 1'b1;
            tsel_next    = TBL_ADV;
            state_next   = S_START;
          end
        end
      end
      S_START: begin
        addr_next = '0;
        if (npts == '0) begin
          cmd.res_we  = 1'b1;
          cmd.res_src = RES_EMPTY;
          if (tsel == TBL_ADV) begin
            tsel_next = TBL_DWL;
          end else begin
            state_next = S_DONE;
          end
        end else begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (stat.le && addr != '0 && stat.seg_up) begin
          state_next = S_MUL;
        end else if (stat.le || last_pt) begin
          cmd.res_we    = 1'b1;
          cmd.res_src   = RES_CUR;
          cmd.save_prev = !stat.le;
          if (tsel == TBL_ADV) begin
            tsel_next  = TBL_DWL;
            state_next = S_START;
          end else begin
            state_next = S_DONE;
          end
        end else begin
          cmd.save_prev = 1'b1;
          addr_next     = addr + 1'b1;
          state_next    = S_RD;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == DIV_CW'(DIV_STEPS - 1)) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.res_we  = 1'b1;
        cmd.res_src = RES_INTERP;
        if (tsel == TBL_ADV) begin
          tsel_next  = TBL_DWL;
          state_next = S_START;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tsel      <= TBL_ADV;
      addr      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      tsel      <= tsel_next;
      addr      <= addr_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // A finished result waits in S_DONE until the output word is free
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !out_ready) |=> state == S_DONE)
    else $error("finished lookup left S_DONE while output word was occupied");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("output word loaded without valid");

  a_mul_div: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |=> (state == S_DIV && cnt == '0))
    else $error("divider did not start from step zero");

  a_cmp_after_rd: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> $past(state) == S_RD)
    else $error("compare without a preceding table read");

  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RD |-> int'(addr) < int'(npts))
    else $error("table read past the points in use");

endmodule

FILE: tb/tb_ignition_map_interpolator_top.sv
module tb_ignition_map_interpolator_top;
  import imi_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int SETTLE_CYCLES  = 150;
  localparam int TIMEOUT_CYCLES = 1000000;
  localparam int PRINT_LIMIT    = 40;
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  typedef struct {
    logic [15:0]        speed;
    logic signed [15:0] advance;
    logic [15:0]        dwell;
  } lookup_result_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          mode;
  logic [3:0]          entry_index;
  logic [15:0]         rpm;
  logic [15:0]         entry_value;
  logic                out_valid;
  logic                out_ready;
  logic signed [15:0]  advance_cd;
  logic [15:0]         dwell_time;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // Mirror of the block's tables and registers
  logic [15:0] bp_speed [2][MAX_DEPTH];
  logic [15:0] bp_value [2][MAX_DEPTH];
  int          cfg_adv_pts;
  int          cfg_dwl_pts;
  int          cfg_dwl_default;
  int          cfg_dwl_floor;
  int          cfg_dwl_ceiling;

  lookup_result_t pending_lookups [$];
  int             mismatches;
  bit             steady;
  int             hold_off_cycles;

  ignition_map_interpolator_top uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .entry_index (entry_index),
    .rpm         (rpm),
    .entry_value (entry_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .advance_cd  (advance_cd),
    .dwell_time  (dwell_time),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic longint point_value(tbl_t t, int i);
    if (t == TBL_ADV) return longint'($signed(bp_value[t][i]));
    return longint'(bp_value[t][i]);
  endfunction

  // Piecewise linear search over the first n breakpoints of one table
  function automatic longint seg_lookup(tbl_t t, logic [15:0] speed, int n);
    longint x0, x1, y0, y1;
    if (speed <= bp_speed[t][0]) return point_value(t, 0);
    for (int i = 1; i < n; i++) begin
      if (speed <= bp_speed[t][i]) begin
        x0 = bp_speed[t][i-1];
        x1 = bp_speed[t][i];
        y0 = point_value(t, i - 1);
        y1 = point_value(t, i);
        if (x1 <= x0) return y1;
        return y0 + ((longint'(speed) - x0) * (y1 - y0)) / (x1 - x0);
      end
    end
    return point_value(t, n - 1);
  endfunction

  function automatic lookup_result_t predict_lookup(logic [15:0] speed);
    lookup_result_t res;
    longint adv, dwl;
    int n;
    n = (cfg_adv_pts > ADV_DEPTH) ? ADV_DEPTH : cfg_adv_pts;
    if (n == 0) begin
      adv = ADV_EMPTY_CD;
    end else begin
      adv = seg_lookup(TBL_ADV, speed, n);
      if (adv > 32767) adv = 32767;
      if (adv < -32768) adv = -32768;
    end
    n = (cfg_dwl_pts > DWL_DEPTH) ? DWL_DEPTH : cfg_dwl_pts;
    if (n == 0) begin
      dwl = cfg_dwl_default;
    end else begin
      dwl = seg_lookup(TBL_DWL, speed, n);
      if (dwl < cfg_dwl_floor) dwl = cfg_dwl_floor;
      if (dwl > cfg_dwl_ceiling) dwl = cfg_dwl_ceiling;
    end
    res.speed   = speed;
    res.advance = adv[15:0];
    res.dwell   = dwl[15:0];
    return res;
  endfunction

  // Offer one word, hold it until taken, then apply it to the mirror
  task automatic send_word(logic [1:0] m, logic [3:0] idx, logic [15:0] speed,
                           logic [15:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    entry_index <= idx;
    rpm         <= speed;
    entry_value <= val;
    do @(posedge clk); while (in_ready !== 1'b1);
    case (m)
      MODE_LOOKUP: pending_lookups.push_back(predict_lookup(speed));
      MODE_WR_ADV: begin
        bp_speed[TBL_ADV][idx] = speed;
        bp_value[TBL_ADV][idx] = val;
      end
      MODE_WR_DWL: begin
        bp_speed[TBL_DWL][idx] = speed;
        bp_value[TBL_DWL][idx] = val;
      end
      default: ;
    endcase
  endtask

  task automatic lookup(int speed);
    if (speed < 0) speed = 0;
    else if (speed > 65535) speed = 65535;
    send_word(MODE_LOOKUP, 4'($urandom), 16'(speed), 16'($urandom));
  endtask

  // Drop valid, drain all results, then let any trailing write finish
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register, mirror it, read it back
  task automatic write_reg(reg_idx_t r, int v);
    logic [31:0] mask;
    mask = (r == REG_ADV_PTS || r == REG_DWL_PTS) ? 32'h1F : 32'hFFFF;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(int'(r) * 4);
    pwdata  <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (r)
      REG_ADV_PTS:   cfg_adv_pts     = v & mask;
      REG_DWL_PTS:   cfg_dwl_pts     = v & mask;
      REG_DWL_DEF:   cfg_dwl_default = v & mask;
      REG_DWL_FLOOR: cfg_dwl_floor   = v & mask;
      REG_DWL_CEIL:  cfg_dwl_ceiling = v & mask;
      default: ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if ((prdata & mask) !== (32'(v) & mask))
      report_mismatch($sformatf("register %s read %0h expected %0h", r.name(),
                                prdata & mask, 32'(v) & mask));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Load every slot of both tables with non-decreasing speeds
  task automatic reload_map(bit extremes);
    int spd;
    logic [15:0] val;
    for (int t = 0; t < 2; t++) begin
      spd = extremes ? 800 : $urandom_range(0, 3000);
      for (int s = 0; s < MAX_DEPTH; s++) begin
        if (s > 0 && !(extremes && s == 5) && $urandom_range(0, 9) != 0)
          spd = spd + $urandom_range(1, 4000);
        if (spd > 65535) spd = 65535;
        if (extremes && s < 3)
          val = (t == 0) ? ((s == 1) ? 16'h7FFF : 16'h8000) : ((s == 1) ? 16'hFFFF : 16'h0000);
        else if ($urandom_range(0, 7) == 0)
          val = 16'($urandom);
        else if (t == 0)
          val = 16'(int'($urandom_range(0, 7500)) - 1500);
        else
          val = 16'($urandom_range(500, 12000));
        send_word((t == 0) ? MODE_WR_ADV : MODE_WR_DWL, 4'(s), 16'(spd), val);
      end
    end
  endtask

  function automatic int pick_count();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 0;
    if (roll < 3) return $urandom_range(ADV_DEPTH + 1, 31);
    if (roll < 5) return ADV_DEPTH;
    return $urandom_range(1, ADV_DEPTH - 1);
  endfunction

  function automatic int pick_level();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 0;
    if (roll == 1) return 65535;
    return $urandom_range(500, 9000);
  endfunction

  // Empty tables: fixed advance, dwell default without clamping
  task automatic test_empty_tables();
    lookup(0);
    lookup(65535);
    lookup(2500);
    send_word(MODE_IGNORED, 4'hF, 16'hFFFF, 16'hFFFF);
    lookup(1234);
    settle();
    write_reg(REG_DWL_DEF, 0);
    write_reg(REG_DWL_FLOOR, 5000);
    write_reg(REG_DWL_CEIL, 100);
    lookup(7000);
    settle();
    write_reg(REG_DWL_DEF, 65535);
    lookup(40000);
  endtask

  // Full tables with extreme values: ends, breakpoints, midpoints
  task automatic test_map_lookups();
    reload_map(1'b1);
    settle();
    write_reg(REG_ADV_PTS, ADV_DEPTH);
    write_reg(REG_DWL_PTS, DWL_DEPTH);
    write_reg(REG_DWL_FLOOR, 0);
    write_reg(REG_DWL_CEIL, 65535);
    write_reg(REG_DWL_DEF, 3000);
    lookup(0);
    lookup(65535);
    for (int s = 0; s < 3; s++) begin
      lookup(bp_speed[TBL_ADV][s]);
      lookup((bp_speed[TBL_ADV][s] + bp_speed[TBL_ADV][s+1]) / 2);
      lookup((bp_speed[TBL_DWL][s] + bp_speed[TBL_DWL][s+1]) / 2);
    end
    lookup(bp_speed[TBL_ADV][4]);
    lookup(bp_speed[TBL_DWL][15] + 1);
    // break the ordering at slot 9 of both tables
    send_word(MODE_WR_ADV, 4'd9, bp_speed[TBL_ADV][8] - 16'd40, 16'h0123);
    send_word(MODE_WR_DWL, 4'd9, bp_speed[TBL_DWL][8] - 16'd40, 16'h0456);
    lookup(bp_speed[TBL_ADV][8] + 20);
    lookup(bp_speed[TBL_DWL][10]);
  endtask

  // Point counts from zero to beyond depth, floor and ceiling extremes
  task automatic test_point_counts();
    int counts [6];
    counts = '{1, 2, 0, 17, 31, 16};
    for (int i = 0; i < 6; i++) begin
      settle();
      write_reg(REG_ADV_PTS, counts[i]);
      write_reg(REG_DWL_PTS, counts[5 - i]);
      write_reg(REG_DWL_FLOOR, (i == 2) ? 65535 : (i == 4) ? 2000 : 0);
      write_reg(REG_DWL_CEIL, (i == 2) ? 0 : (i == 4) ? 5000 : 65535);
      lookup(0);
      lookup($urandom_range(0, 65535));
      lookup(65535);
    end
  endtask

  // Phases of random settings and mixed traffic
  task automatic test_random_traffic();
    int roll, spd;
    tbl_t tsel;
    for (int p = 0; p < 9; p++) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 1) reload_map(1'b0);
      settle();
      write_reg(REG_ADV_PTS, pick_count());
      write_reg(REG_DWL_PTS, pick_count());
      write_reg(REG_DWL_DEF, pick_level());
      write_reg(REG_DWL_FLOOR, pick_level());
      write_reg(REG_DWL_CEIL, pick_level());
      for (int k = 0; k < 64; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 78) begin
          case ($urandom_range(0, 3))
            0, 1: begin
              tsel = tbl_t'($urandom_range(0, 1));
              spd = int'(bp_speed[tsel][$urandom_range(0, MAX_DEPTH - 1)])
                    + int'($urandom_range(0, 600)) - 300;
            end
            2: spd = $urandom_range(0, 65535);
            default: spd = ($urandom_range(0, 1) == 1) ? 65535 : 0;
          endcase
          lookup(spd);
        end else if (roll < 95) begin
          send_word((roll < 86) ? MODE_WR_ADV : MODE_WR_DWL, 4'($urandom),
                    16'($urandom), 16'($urandom));
        end else begin
          send_word(MODE_IGNORED, 4'($urandom), 16'($urandom), 16'($urandom));
        end
      end
    end
    steady = 1'b0;
  endtask

  // Receiver holds off long enough for the block to back up
  task automatic test_output_backpressure();
    settle();
    steady = 1'b1;
    hold_off_cycles = 400;
    repeat (24) lookup($urandom_range(0, 65535));
    steady = 1'b0;
  endtask

  // Stimulus
  initial begin
    mismatches      = 0;
    steady          = 1'b0;
    hold_off_cycles = 0;
    cfg_adv_pts     = 0;
    cfg_dwl_pts     = 0;
    cfg_dwl_default = DWL_DEF_RST;
    cfg_dwl_floor   = DWL_FLOOR_RST;
    cfg_dwl_ceiling = DWL_CEIL_RST;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    mode        <= MODE_LOOKUP;
    entry_index <= '0;
    rpm         <= '0;
    entry_value <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_tables();
    test_map_lookups();
    test_point_counts();
    test_random_traffic();
    test_output_backpressure();
    settle();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result side ready: random stalls, and one long hold when asked
  initial begin
    int held, gap;
    forever begin
      if (hold_off_cycles != 0) begin
        held = hold_off_cycles;
        hold_off_cycles = 0;
        out_ready <= 1'b0;
        while (held != 0) begin
          @(posedge clk);
          held--;
        end
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        gap = pick_gap();
        if (gap == 0) gap = 1;
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare each result word with the oldest predicted lookup
  initial begin
    lookup_result_t want;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && out_valid === 1'b1 && out_ready === 1'b1) begin
        if (pending_lookups.size() == 0) begin
          report_mismatch($sformatf("result word with no lookup pending: %0d %0d",
                                    advance_cd, dwell_time));
        end else begin
          want = pending_lookups.pop_front();
          if (advance_cd !== want.advance)
            report_mismatch($sformatf("rpm %0d advance_cd %0d expected %0d",
                                      want.speed, advance_cd, want.advance));
          if (dwell_time !== want.dwell)
            report_mismatch($sformatf("rpm %0d dwell_time %0d expected %0d",
                                      want.speed, dwell_time, want.dwell));
        end
      end
    end
  end

  // Stop a hung run
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
